// ----- rtl/core/mlf_pkg.sv -----
// Package for the Manning link flux pipeline: field widths, beat types
// and the sideband records carried between pipeline sections. No dependencies.
package mlf_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DEPTH_W = 24;
    localparam int ELEV_W  = 32;
    localparam int WIDTH_W = 32;
    localparam int ROUGH_W = 16;
    localparam int LEN_W   = 32;
    localparam int FLOW_W  = 48;

    // internal widths
    localparam int LEVEL_W = ELEV_W + 2;
    localparam int DIFF_W  = LEVEL_W + 1;
    localparam int ADH_W   = LEVEL_W;
    localparam int WS_W    = WIDTH_W + 1;
    localparam int NS_W    = ROUGH_W + 1;
    localparam int LS_W    = LEN_W + 1;
    localparam int G_NUM_W = ADH_W + 1 + FRAC_BITS;
    localparam int SQ_RW   = (G_NUM_W + FRAC_BITS + 1) / 2;
    localparam int SQ_XW   = 2 * SQ_RW;
    localparam int D2_W    = 2 * DEPTH_W;
    localparam int CB_RW   = (D2_W + FRAC_BITS + 2) / 3;
    localparam int CB_XW   = 3 * CB_RW;
    localparam int P_W     = DEPTH_W + CB_RW - FRAC_BITS;
    localparam int M_W     = P_W + SQ_RW - FRAC_BITS;
    localparam int M_HALF  = M_W / 2;
    localparam int PP_W    = M_HALF + WS_W;
    localparam int A_W     = M_W + WS_W;
    localparam int Q_W     = FLOW_W;
    localparam int AHI_W   = A_W - Q_W;

    localparam logic [Q_W-1:0] POS_LIMIT = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic [DEPTH_W-1:0]       up_water;
        logic [DEPTH_W-1:0]       dn_water;
        logic signed [ELEV_W-1:0] up_elev;
        logic signed [ELEV_W-1:0] dn_elev;
        logic [WIDTH_W-1:0]       up_width;
        logic [WIDTH_W-1:0]       dn_width;
        logic [ROUGH_W-1:0]       up_rough;
        logic [ROUGH_W-1:0]       dn_rough;
        logic [LEN_W-1:0]         up_len;
        logic [LEN_W-1:0]         dn_len;
    } link_t;

    typedef struct packed {
        logic signed [FLOW_W-1:0] flow_rate;
        logic                     saturated;
        logic                     invalid;
    } flux_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [ADH_W-1:0]   adh;
        logic               neg;
        logic [WS_W-1:0]    ws;
        logic [NS_W-1:0]    ns;
        logic [LS_W-1:0]    ls;
        logic               invalid;
    } cb_side_t;

    typedef struct packed {
        logic [P_W-1:0]  p;
        logic            neg;
        logic [WS_W-1:0] ws;
        logic [NS_W-1:0] ns;
        logic            invalid;
    } gd_side_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic invalid;
    } fd_side_t;

endpackage

// ----- rtl/core/manning_link_flux.sv -----
// Top level of the Manning link flux pipeline.
// Uses mlf_pkg, mlf_cbrt, mlf_udiv and mlf_isqrt.
//
// Usage:
//   link channel (link_valid / link_stall / link) carries one link beat: depth,
//   bed elevation, width, roughness and length of the upstream and downstream
//   cells. flux channel (flux_valid / flux_stall / flux) returns one beat per
//   link: signed discharge, saturated flag, invalid flag, in input order.
//   A beat moves on a rising edge with valid high and stall low.
//   Throughput: one link per cycle while not stalled. Every section is fully
//   pipelined: cube root (22 stages), gradient divider (51), square root (34),
//   discharge divider (48), plus eight stages for sums, products and limits.
//   Stall: the whole pipe advances together; while the flux output register
//   holds a beat and flux_stall is high, link_stall is high and every stage
//   holds. With the output register empty, links are taken even if flux_stall
//   is high.
//   Reset: rst_n clears all stage valid bits; no state survives a link.
module manning_link_flux
    import mlf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  link_valid,
    output logic  link_stall,
    input  link_t link,
    output logic  flux_valid,
    input  logic  flux_stall,
    output flux_t flux
);

    logic advance;
    logic flux_valid_reg;
    flux_t flux_reg, flux_next;

    assign advance    = !(flux_valid_reg && flux_stall);
    assign link_stall = !advance;

    // stage 1: levels, sums, upwind depth
    logic     s1_valid_reg;
    cb_side_t s1_reg, s1_next;

    always_comb
    begin
        logic signed [LEVEL_W-1:0] uh, dh;
        logic signed [DIFF_W-1:0]  diff, t;
        logic signed [DIFF_W-1:0]  ud, dd, ue, de;
        ud   = $signed({{(DIFF_W-DEPTH_W){1'b0}}, link.up_water});
        dd   = $signed({{(DIFF_W-DEPTH_W){1'b0}}, link.dn_water});
        ue   = $signed({{(DIFF_W-ELEV_W){link.up_elev[ELEV_W-1]}}, link.up_elev});
        de   = $signed({{(DIFF_W-ELEV_W){link.dn_elev[ELEV_W-1]}}, link.dn_elev});
        uh   = LEVEL_W'(ud + ue);
        dh   = LEVEL_W'(dd + de);
        diff = $signed({uh[LEVEL_W-1], uh}) - $signed({dh[LEVEL_W-1], dh});
        if (uh >= dh)
            t = (ue < de) ? (ud + ue - de) : ud;
        else
            t = (de < ue) ? (dd + de - ue) : dd;
        s1_next.depth   = (t < 0) ? '0 : t[DEPTH_W-1:0];
        s1_next.neg     = diff < 0;
        s1_next.adh     = diff < 0 ? ADH_W'(-diff) : ADH_W'(diff);
        s1_next.ws      = {1'b0, link.up_width} + {1'b0, link.dn_width};
        s1_next.ns      = {1'b0, link.up_rough} + {1'b0, link.dn_rough};
        s1_next.ls      = {1'b0, link.up_len} + {1'b0, link.dn_len};
        s1_next.invalid = (s1_next.ns == '0) || (s1_next.ls == '0);
    end

    // stage 2: depth squared
    logic              s2_valid_reg;
    cb_side_t          s2_reg;
    logic [D2_W-1:0]   d2_reg;

    // cube root section output
    logic              cb_valid;
    logic [CB_RW-1:0]  cb_root;
    cb_side_t          cb_side;

    // stage after cube root: depth^(5/3)
    logic              s3_valid_reg;
    cb_side_t          s3_reg;
    logic [P_W-1:0]    p_reg;
    logic [D2_W-1:0]   p_full;

    // gradient divider and square root
    gd_side_t          gd_side_in, gd_side, sq_side;
    logic              gd_valid, sq_valid;
    logic [G_NUM_W-1:0] g_quo;
    logic [SQ_RW-1:0]  s_root;

    // discharge product stages
    logic              s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    gd_side_t          s4_reg, s5_reg, s6_reg;
    logic [M_W-1:0]    m_reg;
    logic [2*SQ_RW-1:0] m_full;
    logic [PP_W-1:0]   plo_reg, phi_reg;
    logic [A_W-1:0]    a_reg;
    fd_side_t          s7_reg, fd_side;
    logic [Q_W-1:0]    num7_reg;
    logic [NS_W-1:0]   ns7_reg, rem7_reg;
    logic              ovf;
    logic              fd_valid;
    logic [Q_W-1:0]    q_quo;

    assign p_full = D2_W'(cb_side.depth) * D2_W'(cb_root);
    assign m_full = (2*SQ_RW)'(sq_side.p) * (2*SQ_RW)'(s_root);
    assign ovf    = a_reg[A_W-1 -: AHI_W] >= AHI_W'(s6_reg.ns);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            s6_valid_reg   <= 1'b0;
            s7_valid_reg   <= 1'b0;
            flux_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg   <= link_valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= cb_valid;
            s4_valid_reg   <= sq_valid;
            s5_valid_reg   <= s4_valid_reg;
            s6_valid_reg   <= s5_valid_reg;
            s7_valid_reg   <= s6_valid_reg;
            flux_valid_reg <= fd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            d2_reg   <= D2_W'(s1_reg.depth) * D2_W'(s1_reg.depth);
            s3_reg   <= cb_side;
            p_reg    <= p_full[FRAC_BITS +: P_W];
            s4_reg   <= sq_side;
            m_reg    <= m_full[FRAC_BITS +: M_W];
            s5_reg   <= s4_reg;
            plo_reg  <= PP_W'(m_reg[M_HALF-1:0]) * PP_W'(s4_reg.ws);
            phi_reg  <= PP_W'(m_reg[M_W-1:M_HALF]) * PP_W'(s4_reg.ws);
            s6_reg   <= s5_reg;
            a_reg    <= (A_W'(phi_reg) << M_HALF) + A_W'(plo_reg);
            s7_reg.neg     <= s6_reg.neg;
            s7_reg.invalid <= s6_reg.invalid;
            s7_reg.ovf     <= ovf;
            num7_reg <= a_reg[Q_W-1:0];
            ns7_reg  <= s6_reg.ns;
            // remainder start is the high part, below the divisor when no overflow
            rem7_reg <= ovf ? '0 : a_reg[Q_W +: NS_W];
            flux_reg <= flux_next;
        end
    end

    mlf_cbrt #(
        .ROOT_W (CB_RW),
        .SIDE_W ($bits(cb_side_t))
    ) u_cbrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .src_valid (s2_valid_reg),
        .radicand  (CB_XW'({d2_reg, {FRAC_BITS{1'b0}}})),
        .side      (s2_reg),
        .res_valid (cb_valid),
        .root      (cb_root),
        .res_side  (cb_side)
    );

    always_comb
    begin
        gd_side_in.p       = p_reg;
        gd_side_in.neg     = s3_reg.neg;
        gd_side_in.ws      = s3_reg.ws;
        gd_side_in.ns      = s3_reg.ns;
        gd_side_in.invalid = s3_reg.invalid;
    end

    mlf_udiv #(
        .NUM_W  (G_NUM_W),
        .DEN_W  (LS_W),
        .SIDE_W ($bits(gd_side_t))
    ) u_grad_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .src_valid (s3_valid_reg),
        .num       ({s3_reg.adh, 1'b0, {FRAC_BITS{1'b0}}}),
        .den       (s3_reg.ls),
        .rem_init  ({LS_W{1'b0}}),
        .side      (gd_side_in),
        .res_valid (gd_valid),
        .quo       (g_quo),
        .res_side  (gd_side)
    );

    mlf_isqrt #(
        .ROOT_W (SQ_RW),
        .SIDE_W ($bits(gd_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .src_valid (gd_valid),
        .radicand  (SQ_XW'({g_quo, {FRAC_BITS{1'b0}}})),
        .side      (gd_side),
        .res_valid (sq_valid),
        .root      (s_root),
        .res_side  (sq_side)
    );

    mlf_udiv #(
        .NUM_W  (Q_W),
        .DEN_W  (NS_W),
        .SIDE_W ($bits(fd_side_t))
    ) u_flow_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .src_valid (s7_valid_reg),
        .num       (num7_reg),
        .den       (ns7_reg),
        .rem_init  (rem7_reg),
        .side      (s7_reg),
        .res_valid (fd_valid),
        .quo       (q_quo),
        .res_side  (fd_side)
    );

    // limits and sign
    always_comb
    begin
        logic [Q_W-1:0] mag;
        logic           sat;
        if (fd_side.neg)
        begin
            sat = fd_side.ovf || (q_quo > NEG_LIMIT);
            mag = sat ? NEG_LIMIT : q_quo;
        end
        else
        begin
            sat = fd_side.ovf || (q_quo > POS_LIMIT);
            mag = sat ? POS_LIMIT : q_quo;
        end
        if (fd_side.invalid)
        begin
            flux_next.flow_rate = '0;
            flux_next.saturated = 1'b0;
            flux_next.invalid   = 1'b1;
        end
        else
        begin
            flux_next.flow_rate = fd_side.neg ? $signed(-mag) : $signed(mag);
            flux_next.saturated = sat;
            flux_next.invalid   = 1'b0;
        end
    end

    assign flux_valid = flux_valid_reg;
    assign flux       = flux_reg;

endmodule

// ----- rtl/core/mlf_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// No package dependencies.
module mlf_udiv #(
    parameter int NUM_W  = 51,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              src_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [SIDE_W-1:0] side,
    output logic              res_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] res_side
);

    logic [NUM_W-1:0]  n_reg  [NUM_W];
    logic [DEN_W-1:0]  r_reg  [NUM_W];
    logic [DEN_W-1:0]  d_reg  [NUM_W];
    logic [SIDE_W-1:0] s_reg  [NUM_W];
    logic              v_reg  [NUM_W];
    logic [NUM_W-1:0]  n_src  [NUM_W];
    logic [DEN_W-1:0]  r_src  [NUM_W];
    logic [DEN_W-1:0]  d_src  [NUM_W];
    logic [SIDE_W-1:0] s_src  [NUM_W];
    logic              v_src  [NUM_W];
    logic [NUM_W-1:0]  n_next [NUM_W];
    logic [DEN_W-1:0]  r_next [NUM_W];

    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           ge;
        n_src[0] = num;
        r_src[0] = rem_init;
        d_src[0] = den;
        s_src[0] = side;
        v_src[0] = src_valid;
        for (int k = 1; k < NUM_W; k++)
        begin
            n_src[k] = n_reg[k-1];
            r_src[k] = r_reg[k-1];
            d_src[k] = d_reg[k-1];
            s_src[k] = s_reg[k-1];
            v_src[k] = v_reg[k-1];
        end
        for (int k = 0; k < NUM_W; k++)
        begin
            trial     = {r_src[k], n_src[k][NUM_W-1]};
            ge        = trial >= {1'b0, d_src[k]};
            r_next[k] = ge ? DEN_W'(trial - {1'b0, d_src[k]}) : trial[DEN_W-1:0];
            n_next[k] = {n_src[k][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_W; k++)
                v_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            for (int k = 0; k < NUM_W; k++)
                v_reg[k] <= v_src[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
                d_reg[k] <= d_src[k];
                s_reg[k] <= s_src[k];
            end
        end
    end

    assign res_valid = v_reg[NUM_W-1];
    assign quo       = n_reg[NUM_W-1];
    assign res_side  = s_reg[NUM_W-1];

endmodule

// ----- rtl/core/mlf_isqrt.sv -----
// Pipelined integer square root, one root bit per stage (digit recurrence).
// No package dependencies.
module mlf_isqrt #(
    parameter int ROOT_W = 34,
    parameter int SIDE_W = 1
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  src_valid,
    input  logic [2*ROOT_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]     side,
    output logic                  res_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     res_side
);

    localparam int XW  = 2 * ROOT_W;
    localparam int RMW = ROOT_W + 2;
    localparam int TW  = RMW + 2;

    logic [XW-1:0]     x_reg  [ROOT_W];
    logic [ROOT_W-1:0] r_reg  [ROOT_W];
    logic [RMW-1:0]    m_reg  [ROOT_W];
    logic [SIDE_W-1:0] s_reg  [ROOT_W];
    logic              v_reg  [ROOT_W];
    logic [XW-1:0]     x_src  [ROOT_W];
    logic [ROOT_W-1:0] r_src  [ROOT_W];
    logic [RMW-1:0]    m_src  [ROOT_W];
    logic [SIDE_W-1:0] s_src  [ROOT_W];
    logic              v_src  [ROOT_W];
    logic [ROOT_W-1:0] r_next [ROOT_W];
    logic [RMW-1:0]    m_next [ROOT_W];

    always_comb
    begin
        logic [TW-1:0] trial;
        logic [TW-1:0] b;
        logic          ge;
        x_src[0] = radicand;
        r_src[0] = '0;
        m_src[0] = '0;
        s_src[0] = side;
        v_src[0] = src_valid;
        for (int k = 1; k < ROOT_W; k++)
        begin
            x_src[k] = x_reg[k-1];
            r_src[k] = r_reg[k-1];
            m_src[k] = m_reg[k-1];
            s_src[k] = s_reg[k-1];
            v_src[k] = v_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial     = {m_src[k], x_src[k][XW-1 -: 2]};
            b         = TW'({r_src[k], 2'b01});
            ge        = trial >= b;
            m_next[k] = ge ? RMW'(trial - b) : RMW'(trial);
            r_next[k] = {r_src[k][ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_W; k++)
                v_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            for (int k = 0; k < ROOT_W; k++)
                v_reg[k] <= v_src[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                x_reg[k] <= x_src[k] << 2;
                r_reg[k] <= r_next[k];
                m_reg[k] <= m_next[k];
                s_reg[k] <= s_src[k];
            end
        end
    end

    assign res_valid = v_reg[ROOT_W-1];
    assign root      = r_reg[ROOT_W-1];
    assign res_side  = s_reg[ROOT_W-1];

endmodule

// ----- rtl/core/mlf_cbrt.sv -----
// Pipelined integer cube root, one root bit per stage; keeps root^2 alongside
// so each step needs only shifts and adds. No package dependencies.
module mlf_cbrt #(
    parameter int ROOT_W = 22,
    parameter int SIDE_W = 1
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  src_valid,
    input  logic [3*ROOT_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]     side,
    output logic                  res_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     res_side
);

    localparam int XW  = 3 * ROOT_W;
    localparam int QW  = 2 * ROOT_W;
    localparam int RMW = 2 * ROOT_W + 2;
    localparam int TW  = RMW + 3;

    logic [XW-1:0]     x_reg  [ROOT_W];
    logic [ROOT_W-1:0] r_reg  [ROOT_W];
    logic [QW-1:0]     q_reg  [ROOT_W];
    logic [RMW-1:0]    m_reg  [ROOT_W];
    logic [SIDE_W-1:0] s_reg  [ROOT_W];
    logic              v_reg  [ROOT_W];
    logic [XW-1:0]     x_src  [ROOT_W];
    logic [ROOT_W-1:0] r_src  [ROOT_W];
    logic [QW-1:0]     q_src  [ROOT_W];
    logic [RMW-1:0]    m_src  [ROOT_W];
    logic [SIDE_W-1:0] s_src  [ROOT_W];
    logic              v_src  [ROOT_W];
    logic [ROOT_W-1:0] r_next [ROOT_W];
    logic [QW-1:0]     q_next [ROOT_W];
    logic [RMW-1:0]    m_next [ROOT_W];

    always_comb
    begin
        logic [TW-1:0] trial;
        logic [TW-1:0] b;
        logic          ge;
        x_src[0] = radicand;
        r_src[0] = '0;
        q_src[0] = '0;
        m_src[0] = '0;
        s_src[0] = side;
        v_src[0] = src_valid;
        for (int k = 1; k < ROOT_W; k++)
        begin
            x_src[k] = x_reg[k-1];
            r_src[k] = r_reg[k-1];
            q_src[k] = q_reg[k-1];
            m_src[k] = m_reg[k-1];
            s_src[k] = s_reg[k-1];
            v_src[k] = v_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial = {m_src[k], x_src[k][XW-1 -: 3]};
            // (2r+1)^3 - (2r)^3 = 12 r^2 + 6 r + 1
            b = (TW'(q_src[k]) << 3) + (TW'(q_src[k]) << 2)
              + (TW'(r_src[k]) << 2) + (TW'(r_src[k]) << 1) + TW'(1);
            ge        = trial >= b;
            m_next[k] = ge ? RMW'(trial - b) : RMW'(trial);
            q_next[k] = ge ? (q_src[k] << 2) + (QW'(r_src[k]) << 2) + QW'(1)
                           : (q_src[k] << 2);
            r_next[k] = {r_src[k][ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_W; k++)
                v_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            for (int k = 0; k < ROOT_W; k++)
                v_reg[k] <= v_src[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                x_reg[k] <= x_src[k] << 3;
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
                m_reg[k] <= m_next[k];
                s_reg[k] <= s_src[k];
            end
        end
    end

    assign res_valid = v_reg[ROOT_W-1];
    assign root      = r_reg[ROOT_W-1];
    assign res_side  = s_reg[ROOT_W-1];

endmodule
